### rtl/core/wallpaper_pixel_generator_defines.svh
// Assertion macros used by the wallpaper pixel generator port checker.
`ifndef WALLPAPER_PIXEL_GENERATOR_DEFINES_SVH
`define WALLPAPER_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while rst_n is low.
`define WPG_ASSERT_IMPL(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define WPG_ASSERT_NEXT(lbl, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wpg_pkg.sv
// Types and constants of the wallpaper pixel generator.
package wpg_pkg;

    localparam int W_PIX  = 12;
    localparam int W_DIM  = 13;
    localparam int W_RSQ  = 25;
    localparam int W_D2   = 27;
    localparam int W_GNUM = 20;
    localparam int N_GEO  = 6;

    localparam logic [15:0] RECIP_100   = 16'd41943;
    localparam int          RECIP_SHIFT = 22;
    localparam logic [15:0] DIV255_MUL  = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    // cx1, cy1, rad1, cx2, cy2, rad2
    localparam logic [6:0] GEO_PCT [N_GEO] = '{7'd82, 7'd6, 7'd55, 7'd10, 7'd96, 7'd42};
    localparam logic       GEO_ON_H [N_GEO] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

    localparam logic [7:0] COL_BASE0 [3] = '{8'h0E, 8'h11, 8'h24};
    localparam logic [7:0] COL_BASE1 [3] = '{8'h2C, 8'h16, 8'h46};
    localparam logic [7:0] COL_GLOW1 [3] = '{8'h10, 8'h26, 8'h5E};
    localparam logic [7:0] COL_GLOW2 [3] = '{8'h06, 8'h30, 8'h2E};

    localparam logic [3:0] DITHER [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_DARKEN_AMOUNT = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [W_PIX-1:0] pixel_x;
        logic [W_PIX-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    typedef struct packed {
        logic [W_DIM-1:0]            wm1;
        logic [W_DIM-1:0]            hm1;
        logic [1:0][W_DIM-1:0]       cx;
        logic [1:0][W_DIM-1:0]       cy;
        logic [1:0][W_RSQ-1:0]       rsq;
        logic [7:0]                  keep;
    } t_geom;

endpackage

### rtl/core/wallpaper_pixel_generator.sv
// Throughput: one pixel per cycle while not stalled; two pipelined dividers (8 and 9 stages) set the depth.
// A two-entry output register and skid stage hold results; input stalls only while the skid stage is full.
// Reset (synchronous, active low) clears all valid bits and restores register defaults;
// derived glow geometry is registered in wpg_geometry and settles after reset or a register write.
module wallpaper_pixel_generator
    import wpg_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pix_in     i_pix,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_pix_out    o_pix,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    t_geom geom;
    logic  en;

    logic             r_v1;
    logic [W_PIX-1:0] r_1_x, r_1_y, n_1_x, n_1_y;
    logic [W_DIM-1:0] r_1_wm1, r_1_hm1;

    logic [18:0]      tdiv_num [2];
    logic [W_DIM-1:0] tdiv_den [2];
    logic [7:0]       tdiv_quo [2];
    logic [23:0]      tdiv_side;
    logic             tdiv_valid;
    logic [W_PIX-1:0] t_x, t_y;

    logic              r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg;
    logic [8:0]        r_a_t, r_b_t, r_c_t, r_d_t;
    logic [3:0]        r_a_dith, r_b_dith, r_c_dith, r_d_dith;
    logic signed [13:0] r_a_dx [2], r_a_dy [2], n_a_dx [2], n_a_dy [2];
    logic signed [27:0] sq_x [2], sq_y [2];
    logic [25:0]       r_b_sqx [2], r_b_sqy [2];
    logic [W_D2-1:0]   r_c_d2 [2];

    logic [32:0]       gdiv_num [2];
    logic [W_RSQ-1:0]  gdiv_den [2];
    logic [8:0]        gdiv_quo [2];
    logic [12:0]       gdiv_side;
    logic              gdiv_valid;
    logic [17:0]       wt_sq [2];
    logic [8:0]        r_d_wt [2];

    logic [16:0]       n_e_f [3], r_e_f [3];
    logic [7:0]        clamp_c [3];
    logic [15:0]       n_f_p [3], r_f_p [3];
    logic [31:0]       div_m [3];
    t_pix_out          n_g_pix, r_g_pix;

    logic              r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    t_pix_out          r_out, n_out, r_skid, n_skid;

    wpg_geometry #(
        .MAX_DIM(MAX_DIM)
    ) u_geometry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_geom     (geom)
    );

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_comb begin
        n_1_x = ({1'b0, i_pix.pixel_x} > geom.wm1) ? geom.wm1[W_PIX-1:0] : i_pix.pixel_x;
        n_1_y = ({1'b0, i_pix.pixel_y} > geom.hm1) ? geom.hm1[W_PIX-1:0] : i_pix.pixel_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_va <= tdiv_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= gdiv_valid;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_vg <= r_vf;
        end
    end

    always_comb begin
        tdiv_num[0] = {r_1_x, 7'b0};
        tdiv_num[1] = {r_1_y, 7'b0};
        tdiv_den[0] = r_1_wm1;
        tdiv_den[1] = r_1_hm1;
    end

    wpg_div_pipe #(
        .NL(2), .NW(19), .DW(W_DIM), .QW(8), .SW(24)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_num   (tdiv_num),
        .i_den   (tdiv_den),
        .i_side  ({r_1_x, r_1_y}),
        .o_valid (tdiv_valid),
        .o_quo   (tdiv_quo),
        .o_side  (tdiv_side)
    );

    assign t_x = tdiv_side[23:12];
    assign t_y = tdiv_side[11:0];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_a_dx[k] = signed'({2'b0, t_x}) - signed'({1'b0, geom.cx[k]});
            n_a_dy[k] = signed'({2'b0, t_y}) - signed'({1'b0, geom.cy[k]});
            sq_x[k]   = 28'(r_a_dx[k]) * 28'(r_a_dx[k]);
            sq_y[k]   = 28'(r_a_dy[k]) * 28'(r_a_dy[k]);
            if ({2'b0, geom.rsq[k]} > r_c_d2[k]) begin
                gdiv_num[k] = {W_RSQ'(27'(geom.rsq[k]) - r_c_d2[k]), 8'b0};
                gdiv_den[k] = geom.rsq[k];
            end else begin
                gdiv_num[k] = '0;
                gdiv_den[k] = W_RSQ'(1);
            end
            wt_sq[k] = 18'(gdiv_quo[k]) * 18'(gdiv_quo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_1_x    <= n_1_x;
            r_1_y    <= n_1_y;
            r_1_wm1  <= geom.wm1;
            r_1_hm1  <= geom.hm1;
            r_a_t    <= 9'(tdiv_quo[0]) + 9'(tdiv_quo[1]);
            r_a_dith <= {t_y[1:0], t_x[1:0]};
            r_a_dx   <= n_a_dx;
            r_a_dy   <= n_a_dy;
            r_b_t    <= r_a_t;
            r_b_dith <= r_a_dith;
            r_c_t    <= r_b_t;
            r_c_dith <= r_b_dith;
            for (int k = 0; k < 2; k++) begin
                r_b_sqx[k] <= sq_x[k][25:0];
                r_b_sqy[k] <= sq_y[k][25:0];
                r_c_d2[k]  <= W_D2'(r_b_sqx[k]) + W_D2'(r_b_sqy[k]);
                r_d_wt[k]  <= wt_sq[k][16:8];
            end
            r_d_t    <= gdiv_side[12:4];
            r_d_dith <= gdiv_side[3:0];
            r_e_f    <= n_e_f;
            r_f_p    <= n_f_p;
            r_g_pix  <= n_g_pix;
        end
    end

    wpg_div_pipe #(
        .NL(2), .NW(33), .DW(W_RSQ), .QW(9), .SW(13)
    ) u_gdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vc),
        .i_num   (gdiv_num),
        .i_den   (gdiv_den),
        .i_side  ({r_c_t, r_c_dith}),
        .o_valid (gdiv_valid),
        .o_quo   (gdiv_quo),
        .o_side  (gdiv_side)
    );

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_e_f[ch] = 17'(COL_BASE0[ch]) * 17'(9'd256 - r_d_t)
                      + 17'(COL_BASE1[ch]) * 17'(r_d_t)
                      + 17'(COL_GLOW1[ch]) * 17'(r_d_wt[0])
                      + 17'(COL_GLOW2[ch]) * 17'(r_d_wt[1])
                      + 17'({DITHER[r_d_dith], 4'b0});
            clamp_c[ch] = (r_e_f[ch][16:8] > 9'd255) ? 8'hFF : r_e_f[ch][15:8];
            n_f_p[ch]   = 16'(clamp_c[ch]) * 16'(geom.keep);
            div_m[ch]   = 32'(r_f_p[ch]) * 32'(DIV255_MUL);
        end
        n_g_pix.red   = div_m[0][DIV255_SHIFT+7:DIV255_SHIFT];
        n_g_pix.green = div_m[1][DIV255_SHIFT+7:DIV255_SHIFT];
        n_g_pix.blue  = div_m[2][DIV255_SHIFT+7:DIV255_SHIFT];
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = r_vg;
                n_out       = r_g_pix;
            end
        end else if (r_vg && en) begin
            n_skid_valid = 1'b1;
            n_skid       = r_g_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_pix       = r_out;

endmodule

### rtl/core/wpg_geometry.sv
// Configuration registers and pipelined glow geometry.
module wpg_geometry
    import wpg_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    output t_geom       o_geom
);

    logic [W_DIM-1:0] r_frame_width, n_frame_width;
    logic [W_DIM-1:0] r_frame_height, n_frame_height;
    logic [7:0]       r_darken_amount, n_darken_amount;

    logic [W_DIM-1:0] wc, hc;

    logic [W_GNUM-1:0] r_num [N_GEO];
    logic [W_GNUM-1:0] r_num2 [N_GEO];
    logic [W_DIM-1:0]  r_q0 [N_GEO];
    logic [W_DIM-1:0]  r_quo [N_GEO];
    logic [W_RSQ-1:0]  r_rsq [2];

    logic [W_GNUM-1:0] n_num [N_GEO];
    logic [W_DIM-1:0]  n_q0 [N_GEO];
    logic [W_DIM-1:0]  n_quo [N_GEO];
    logic [35:0]       recip_p [N_GEO];
    logic [W_GNUM-1:0] rem_v [N_GEO];

    always_comb begin
        n_frame_width   = r_frame_width;
        n_frame_height  = r_frame_height;
        n_darken_amount = r_darken_amount;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:   n_frame_width   = i_cfg_data;
                REG_FRAME_HEIGHT:  n_frame_height  = i_cfg_data;
                REG_DARKEN_AMOUNT: n_darken_amount = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 13'd1024;
            r_frame_height  <= 13'd768;
            r_darken_amount <= 8'd80;
        end else begin
            r_frame_width   <= n_frame_width;
            r_frame_height  <= n_frame_height;
            r_darken_amount <= n_darken_amount;
        end
    end

    always_comb begin
        if (r_frame_width < 13'd2) begin
            wc = 13'd2;
        end else if ({1'b0, r_frame_width} > 14'(MAX_DIM)) begin
            wc = W_DIM'(MAX_DIM);
        end else begin
            wc = r_frame_width;
        end
        if (r_frame_height < 13'd2) begin
            hc = 13'd2;
        end else if ({1'b0, r_frame_height} > 14'(MAX_DIM)) begin
            hc = W_DIM'(MAX_DIM);
        end else begin
            hc = r_frame_height;
        end
    end

    always_comb begin
        for (int g = 0; g < N_GEO; g++) begin
            n_num[g]   = W_GNUM'(GEO_ON_H[g] ? hc : wc) * W_GNUM'(GEO_PCT[g]);
            recip_p[g] = 36'(r_num[g]) * 36'(RECIP_100);
            n_q0[g]    = W_DIM'(recip_p[g] >> RECIP_SHIFT);
            rem_v[g]   = r_num2[g] - W_GNUM'(r_q0[g]) * W_GNUM'(7'd100);
            n_quo[g]   = (rem_v[g] >= W_GNUM'(7'd100)) ? r_q0[g] + 13'd1 : r_q0[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_num2 <= r_num;
        r_q0   <= n_q0;
        r_quo  <= n_quo;
        r_rsq[0] <= W_RSQ'(26'(r_quo[2]) * 26'(r_quo[2]));
        r_rsq[1] <= W_RSQ'(26'(r_quo[5]) * 26'(r_quo[5]));
    end

    always_comb begin
        o_geom.wm1    = wc - 13'd1;
        o_geom.hm1    = hc - 13'd1;
        o_geom.cx[0]  = r_quo[0];
        o_geom.cy[0]  = r_quo[1];
        o_geom.cx[1]  = r_quo[3];
        o_geom.cy[1]  = r_quo[4];
        o_geom.rsq[0] = r_rsq[0];
        o_geom.rsq[1] = r_rsq[1];
        o_geom.keep   = 8'd255 - r_darken_amount;
    end

endmodule

### rtl/core/wpg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
module wpg_div_pipe
    import wpg_pkg::*;
#(
    parameter int NL = 2,
    parameter int NW = 19,
    parameter int DW = 13,
    parameter int QW = 8,
    parameter int SW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num [NL],
    input  logic [DW-1:0] i_den [NL],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo [NL],
    output logic [SW-1:0] o_side
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem  [QW][NL];
    logic [DW-1:0] r_den  [QW][NL];
    logic [QW-1:0] r_quo  [QW][NL];
    logic [SW-1:0] r_side [QW];
    logic [QW-1:0] r_vld;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic [NW-1:0] rem_in  [NL];
        logic [DW-1:0] den_in  [NL];
        logic [QW-1:0] quo_in  [NL];
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [NW-1:0] n_rem   [NL];
        logic [QW-1:0] n_quo   [NL];

        if (s == 0) begin : g_first
            always_comb begin
                rem_in  = i_num;
                den_in  = i_den;
                side_in = i_side;
                vld_in  = i_valid;
                for (int l = 0; l < NL; l++) begin
                    quo_in[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                rem_in  = r_rem[s-1];
                den_in  = r_den[s-1];
                quo_in  = r_quo[s-1];
                side_in = r_side[s-1];
                vld_in  = r_vld[s-1];
            end
        end

        always_comb begin
            for (int l = 0; l < NL; l++) begin
                n_rem[l] = rem_in[l];
                n_quo[l] = quo_in[l];
                if (CW'(rem_in[l]) >= (CW'(den_in[l]) << B)) begin
                    n_rem[l]    = NW'(CW'(rem_in[l]) - (CW'(den_in[l]) << B));
                    n_quo[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_den[s]  <= den_in;
                r_quo[s]  <= n_quo;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### rtl/core/wpg_checker.sv
// Port-level checker for the wallpaper pixel generator, bound to the top level.
`include "wallpaper_pixel_generator_defines.svh"

module wpg_checker
    import wpg_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_pix_in     i_pix,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_pix_out    o_pix,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [12:0] i_cfg_data
);

    `WPG_ASSERT_NEXT(a_reset_clears, 1'b1, !i_rst_n, !o_out_valid && !o_in_stall, "reset left output or stall active")
    `WPG_ASSERT_IMPL(a_stall_cause, i_rst_n, o_in_stall, $past(o_out_valid && i_out_stall), "input stalled without a held result")
    `WPG_ASSERT_NEXT(a_skid_holds, i_rst_n, o_in_stall && o_out_valid && i_out_stall, o_in_stall, "skid entry dropped while output held")
    `WPG_ASSERT_NEXT(a_out_hold, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_pix), "stalled result changed")

endmodule

bind wallpaper_pixel_generator wpg_checker u_wpg_checker (.*);

### sim/wallpaper_pixel_generator_checker.sv
// Checker for the wallpaper pixel generator: tracks registers, predicts colors, compares.
module wallpaper_pixel_generator_checker
    import wpg_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_pix_in     i_pix,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_pix_out    i_opix,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_pixels_in,
    output int          o_pixels_out
);

    localparam logic [3:0] BAYER [16] = '{
        4'd0, 4'd8, 4'd2, 4'd10, 4'd12, 4'd4, 4'd14, 4'd6,
        4'd3, 4'd11, 4'd1, 4'd9, 4'd15, 4'd7, 4'd13, 4'd5
    };

    logic [12:0] frame_w;
    logic [12:0] frame_h;
    logic [7:0]  dim_amount;
    t_pix_out    color_q[$];

    function automatic longint clamp_size(logic [12:0] v);
        if (v < 2) return 2;
        if (v > MAX_DIM) return MAX_DIM;
        return longint'(v);
    endfunction

    function automatic longint falloff(longint x, longint y, longint cx, longint cy,
                                       longint rad);
        longint dx, dy, d2, rsq, a;
        dx  = x - cx;
        dy  = y - cy;
        d2  = dx * dx + dy * dy;
        rsq = rad * rad;
        if (rsq <= 0 || d2 >= rsq) return 0;
        a = ((rsq - d2) * 256) / rsq;
        return (a * a) / 256;
    endfunction

    function automatic logic [7:0] tone_channel(longint f, longint dth, longint keep);
        longint c;
        c = (f + dth) / 256;
        if (c > 255) c = 255;
        return 8'((c * keep) / 255);
    endfunction

    function automatic t_pix_out shade_pixel(t_pix_in p);
        longint w, h, x, y, t, rf, gf, bf, a, dth, keep;
        t_pix_out r;
        w = clamp_size(frame_w);
        h = clamp_size(frame_h);
        x = longint'(p.pixel_x);
        y = longint'(p.pixel_y);
        if (x > w - 1) x = w - 1;
        if (y > h - 1) y = h - 1;
        t  = (x * 128) / (w - 1) + (y * 128) / (h - 1);
        rf = 'h0E * (256 - t) + 'h2C * t;
        gf = 'h11 * (256 - t) + 'h16 * t;
        bf = 'h24 * (256 - t) + 'h46 * t;
        a  = falloff(x, y, w * 82 / 100, h * 6 / 100, w * 55 / 100);
        rf += 'h10 * a;
        gf += 'h26 * a;
        bf += 'h5E * a;
        a  = falloff(x, y, w * 10 / 100, h * 96 / 100, w * 42 / 100);
        rf += 'h06 * a;
        gf += 'h30 * a;
        bf += 'h2E * a;
        dth  = longint'(BAYER[{y[1:0], x[1:0]}]) * 16;
        keep = 255 - longint'(dim_amount);
        r.red   = tone_channel(rf, dth, keep);
        r.green = tone_channel(gf, dth, keep);
        r.blue  = tone_channel(bf, dth, keep);
        return r;
    endfunction

    assign o_pending = color_q.size();

    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            frame_w      <= 13'd1024;
            frame_h      <= 13'd768;
            dim_amount   <= 8'd80;
            color_q.delete();
            o_fail_count <= 0;
            o_pixels_in  <= 0;
            o_pixels_out <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH:   frame_w    <= i_cfg_data;
                    REG_FRAME_HEIGHT:  frame_h    <= i_cfg_data;
                    REG_DARKEN_AMOUNT: dim_amount <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                color_q.push_back(shade_pixel(i_pix));
                o_pixels_in <= o_pixels_in + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                o_pixels_out <= o_pixels_out + 1;
                if (color_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected pixel r=%0d g=%0d b=%0d",
                                 i_opix.red, i_opix.green, i_opix.blue);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = color_q.pop_front();
                    if (want.red != i_opix.red || want.green != i_opix.green ||
                        want.blue != i_opix.blue) begin
                        if (o_fail_count < 10)
                            $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     o_pixels_out, want.red, want.green, want.blue,
                                     i_opix.red, i_opix.green, i_opix.blue);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/wallpaper_pixel_generator_tb.sv
// Testbench top for the wallpaper pixel generator: stimulus, stalls and verdict.
module wallpaper_pixel_generator_tb;
    import wpg_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_pix_in     pix_in;
    logic        out_valid;
    logic        out_stall;
    t_pix_out    pix_out;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [12:0] cfg_data;
    int          fail_count;
    int          pending;
    int          pixels_in;
    int          pixels_out;
    bit          quiet;
    bit          hold_req;
    int          cur_w;
    int          cur_h;
    int          settings_done;

    wallpaper_pixel_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_pix       (pix_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_pix       (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    wallpaper_pixel_generator_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_pix        (pix_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_opix       (pix_out),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_pixels_in  (pixels_in),
        .o_pixels_out (pixels_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge i_clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 10);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int clamp_size(int v);
        if (v < 2) return 2;
        if (v > 4096) return 4096;
        return v;
    endfunction

    task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
        if (!quiet && $urandom_range(99) < 10) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid       <= 1'b1;
        pix_in.pixel_x <= x;
        pix_in.pixel_y <= y;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 13'(value);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input int w, input int h, input int dim);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_DARKEN_AMOUNT, dim);
        write_reg(REG_UNUSED, $urandom_range(8191));
        cfg_we <= 1'b0;
        repeat (8) @(posedge i_clk);
        cur_w = clamp_size(w);
        cur_h = clamp_size(h);
        settings_done++;
    endtask

    task automatic random_pixels(input int count);
        int k;
        logic [11:0] x, y;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 80) begin
                x = 12'($urandom_range(cur_w - 1));
                y = 12'($urandom_range(cur_h - 1));
            end else begin
                x = 12'($urandom_range(4095));
                y = 12'($urandom_range(4095));
            end
            send_pixel(x, y);
        end
    endtask

    initial begin
        int p;
        int ws[9];
        int hs[9];
        int ds[9];
        ws = '{1024, 2,    4096, 0, 8191, 640, 3,    4095, 1};
        hs = '{768,  2,    4096, 1, 5000, 480, 4096, 37,   8191};
        ds = '{80,   0,    255,  255, 17, 128, 0,    200,  1};
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        pix_in   = '0;
        cfg_we   = 1'b0;
        cfg_idx  = REG_FRAME_WIDTH;
        cfg_data = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        settings_done = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (8) @(posedge i_clk);
        cur_w = 1024;
        cur_h = 768;

        // reset defaults: corners, beyond the frame, glow centers and edges
        send_pixel(0, 0);
        send_pixel(1023, 767);
        send_pixel(4095, 4095);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(1024, 768);
        send_pixel(839, 46);
        send_pixel(102, 737);
        send_pixel(839, 0);
        send_pixel(288, 46);
        send_pixel(102, 306);
        send_pixel(1, 1);
        send_pixel(2, 3);
        send_pixel(3, 2);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(512, 384);
        send_pixel(1023, 0);
        send_pixel(0, 767);
        random_pixels(150);

        for (p = 0; p < 9; p++) begin
            apply_setting(ws[p], hs[p], ds[p]);
            send_pixel(0, 0);
            send_pixel(4095, 4095);
            send_pixel(12'(cur_w - 1), 12'(cur_h - 1));
            if (p == 2) begin
                hold_req = 1'b1;
                random_pixels(200);
            end else if (p == 4) begin
                quiet = 1'b1;
                random_pixels(200);
                quiet = 1'b0;
            end else begin
                random_pixels(150);
            end
        end
        for (p = 0; p < 3; p++) begin
            apply_setting($urandom_range(8191), $urandom_range(8191), $urandom_range(255));
            random_pixels(60);
        end

        drain();
        $display("%0d pixels sent and %0d checked over %0d frame/dim settings",
                 pixels_in, pixels_out, settings_done + 1);
        $display("covered size clamping, off-frame pixels, stalls and a long output hold-off");
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
